// ===== rtl/nec_ir_frame_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder: assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_DECODER_CORE_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NECIR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define NECIR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/necir_pkg.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder package
// Widths, codes, reset values and shared types of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package necir_pkg;

    localparam int TIME_W    = 32;
    localparam int CODE_W    = 32;
    localparam int SUM_W     = TIME_W + 1;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 7;
    localparam int BIT_IDX_W = CNT_W - 1;
    localparam int CODE_SEL_W = $clog2(CODE_W);

    localparam int EDGE_CAPACITY    = 68;
    localparam int FULL_FRAME_EDGES = 67;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // input item kinds
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_IDLE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REPEAT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NEW    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT_MIN   = 3'd4;

    localparam logic [CFG_W-1:0] RST_SILENCE_LIMIT = 16'd10000;
    localparam logic [CFG_W-1:0] RST_LEADER_MIN    = 16'd8000;
    localparam logic [CFG_W-1:0] RST_LEADER_MAX    = 16'd10000;
    localparam logic [CFG_W-1:0] RST_REPEAT_GAP    = 16'd2000;
    localparam logic [CFG_W-1:0] RST_ONE_BIT_MIN   = 16'd1400;

    typedef struct packed {
        logic [CFG_W-1:0] silence_limit_us;
        logic [CFG_W-1:0] leader_min_us;
        logic [CFG_W-1:0] leader_max_us;
        logic [CFG_W-1:0] repeat_gap_us;
        logic [CFG_W-1:0] one_bit_min_us;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CODE_W-1:0]   code;
    } result_t;

    // address and command bytes must each be followed by their complement
    function automatic logic complement_ok(input logic [CODE_W-1:0] c);
        complement_ok = ((c[7:0] ^ c[15:8]) == BYTE_MASK) &&
                        ((c[23:16] ^ c[31:24]) == BYTE_MASK);
    endfunction

endpackage

// ===== rtl/necir_cfg.sv =====
// ----------------------------------------------------------------------------
// NEC IR decoder configuration registers
// Five 16-bit timing limits written over a simple valid/ready channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module necir_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [necir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [necir_pkg::CFG_W-1:0]      cfg_data,
    output necir_pkg::cfg_t                  cfg
);

    necir_pkg::cfg_t cfg_reg;
    necir_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                necir_pkg::REG_SILENCE_LIMIT: cfg_next.silence_limit_us = cfg_data;
                necir_pkg::REG_LEADER_MIN:    cfg_next.leader_min_us    = cfg_data;
                necir_pkg::REG_LEADER_MAX:    cfg_next.leader_max_us    = cfg_data;
                necir_pkg::REG_REPEAT_GAP:    cfg_next.repeat_gap_us    = cfg_data;
                necir_pkg::REG_ONE_BIT_MIN:   cfg_next.one_bit_min_us   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.silence_limit_us <= necir_pkg::RST_SILENCE_LIMIT;
            cfg_reg.leader_min_us    <= necir_pkg::RST_LEADER_MIN;
            cfg_reg.leader_max_us    <= necir_pkg::RST_LEADER_MAX;
            cfg_reg.repeat_gap_us    <= necir_pkg::RST_REPEAT_GAP;
            cfg_reg.one_bit_min_us   <= necir_pkg::RST_ONE_BIT_MIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/necir_decode.sv =====
// ----------------------------------------------------------------------------
// NEC IR decoder frame state
// Input register and frame state; decodes one edge or poll per cycle unless res_ready stalls a poll.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module necir_decode (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_command,
    input  logic [necir_pkg::TIME_W-1:0]   in_time_us,
    input  necir_pkg::cfg_t                cfg,
    output logic                           res_valid,
    input  logic                           res_ready,
    output necir_pkg::result_t             res
);

    localparam logic [necir_pkg::CNT_W-1:0] CAP_CNT =
        necir_pkg::CNT_W'(necir_pkg::EDGE_CAPACITY);
    localparam logic [necir_pkg::CNT_W-1:0] FULL_CNT =
        necir_pkg::CNT_W'(necir_pkg::FULL_FRAME_EDGES);
    localparam logic [necir_pkg::CNT_W-1:0] CNT_ONE   = necir_pkg::CNT_W'(1);
    localparam logic [necir_pkg::CNT_W-1:0] CNT_TWO   = necir_pkg::CNT_W'(2);
    localparam logic [necir_pkg::CNT_W-1:0] CNT_THREE = necir_pkg::CNT_W'(3);
    localparam logic [necir_pkg::CNT_W-1:0] CNT_FOUR  = necir_pkg::CNT_W'(4);

    logic                          in_valid_reg;
    logic                          command_reg;
    logic [necir_pkg::TIME_W-1:0]  time_reg;

    logic                          frame_busy_reg,       frame_busy_next;
    logic [necir_pkg::CNT_W-1:0]   edge_count_reg,       edge_count_next;
    logic [necir_pkg::TIME_W-1:0]  last_edge_time_reg,   last_edge_time_next;
    logic                          leader_ok_reg,        leader_ok_next;
    logic                          second_short_reg,     second_short_next;
    logic [necir_pkg::TIME_W-1:0]  first_half_width_reg, first_half_width_next;
    logic [necir_pkg::CODE_W-1:0]  shift_code_reg,       shift_code_next;
    logic [necir_pkg::CODE_W-1:0]  held_code_reg,        held_code_next;

    logic                            advance;
    logic [necir_pkg::TIME_W-1:0]    width;
    logic [necir_pkg::SUM_W-1:0]     pair_sum;
    logic [necir_pkg::CNT_W-1:0]     cnt;
    logic [necir_pkg::CNT_W-1:0]     pair_pos;
    logic [necir_pkg::BIT_IDX_W-1:0] bit_idx;
    logic [necir_pkg::STATUS_W-1:0]  status;

    assign advance   = in_valid_reg && ((command_reg == necir_pkg::CMD_EDGE) || res_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign res_valid = in_valid_reg && (command_reg == necir_pkg::CMD_POLL);

    assign width    = time_reg - last_edge_time_reg;
    assign pair_sum = {1'b0, first_half_width_reg} + {1'b0, width};
    assign cnt      = frame_busy_reg ? edge_count_reg : '0;
    assign pair_pos = cnt - CNT_THREE;
    assign bit_idx  = pair_pos[necir_pkg::CNT_W-1:1];

    always_comb begin
        frame_busy_next       = frame_busy_reg;
        edge_count_next       = edge_count_reg;
        last_edge_time_next   = last_edge_time_reg;
        leader_ok_next        = leader_ok_reg;
        second_short_next     = second_short_reg;
        first_half_width_next = first_half_width_reg;
        shift_code_next       = shift_code_reg;
        held_code_next        = held_code_reg;
        status                = necir_pkg::STATUS_IDLE;

        if (command_reg == necir_pkg::CMD_EDGE) begin
            if (!frame_busy_reg) begin
                frame_busy_next       = 1'b1;
                edge_count_next       = '0;
                leader_ok_next        = 1'b0;
                second_short_next     = 1'b0;
                first_half_width_next = '0;
                shift_code_next       = '0;
            end
            if (cnt < CAP_CNT) begin
                if (cnt == CNT_ONE) begin
                    leader_ok_next = (width >= {16'b0, cfg.leader_min_us}) &&
                                     (width <= {16'b0, cfg.leader_max_us});
                end else if (cnt == CNT_TWO) begin
                    second_short_next = width < {16'b0, cfg.repeat_gap_us};
                end else if (cnt >= CNT_THREE) begin
                    if (!pair_pos[0]) begin
                        first_half_width_next = width;
                    end else if ((32'(bit_idx) < 32'(necir_pkg::CODE_W)) &&
                                 (pair_sum > {17'b0, cfg.one_bit_min_us})) begin
                        shift_code_next = shift_code_reg |
                            (necir_pkg::CODE_W'(1) << bit_idx[necir_pkg::CODE_SEL_W-1:0]);
                    end
                end
                last_edge_time_next = time_reg;
                edge_count_next     = cnt + CNT_ONE;
            end
        end else if (frame_busy_reg && (edge_count_reg != '0) &&
                     (width >= {16'b0, cfg.silence_limit_us})) begin
            frame_busy_next = 1'b0;
            edge_count_next = '0;
            if ((edge_count_reg < CNT_FOUR) || !leader_ok_reg) begin
                status = necir_pkg::STATUS_REJECT;
            end else if (second_short_reg) begin
                status = necir_pkg::STATUS_REPEAT;
            end else if (edge_count_reg < FULL_CNT) begin
                status = necir_pkg::STATUS_REJECT;
            end else if (!necir_pkg::complement_ok(shift_code_reg)) begin
                status = necir_pkg::STATUS_REJECT;
            end else begin
                status         = necir_pkg::STATUS_NEW;
                held_code_next = shift_code_reg;
            end
        end
    end

    assign res.status = status;
    assign res.code   = held_code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            command_reg <= in_command;
            time_reg    <= in_time_us;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_busy_reg       <= 1'b0;
            edge_count_reg       <= '0;
            last_edge_time_reg   <= '0;
            leader_ok_reg        <= 1'b0;
            second_short_reg     <= 1'b0;
            first_half_width_reg <= '0;
            shift_code_reg       <= '0;
            held_code_reg        <= '0;
        end else if (advance) begin
            frame_busy_reg       <= frame_busy_next;
            edge_count_reg       <= edge_count_next;
            last_edge_time_reg   <= last_edge_time_next;
            leader_ok_reg        <= leader_ok_next;
            second_short_reg     <= second_short_next;
            first_half_width_reg <= first_half_width_next;
            shift_code_reg       <= shift_code_next;
            held_code_reg        <= held_code_next;
        end
    end

endmodule

// ===== rtl/necir_outbuf.sv =====
// ----------------------------------------------------------------------------
// NEC IR decoder result register
// Holds one poll result until the downstream transfer completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module necir_outbuf (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             res_valid,
    output logic                             res_ready,
    input  necir_pkg::result_t               res,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [necir_pkg::CODE_W-1:0]     m_tdata,
    output logic [necir_pkg::STATUS_W-1:0]   m_tuser
);

    logic               valid_reg;
    necir_pkg::result_t res_reg;

    assign res_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = res_reg.code;
    assign m_tuser   = res_reg.status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

// ===== rtl/nec_ir_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder core
// Decodes NEC remote frames from timestamped receiver-line edges and polls.
// ----------------------------------------------------------------------------
// Input stream (s_*): one event per transfer. s_tuser[0] is the kind (0 edge,
// 1 poll), s_tdata the 32-bit microsecond timestamp of the event.
// Result stream (m_*): one transfer per poll, none per edge. m_tuser is the
// status (0 nothing ready, 1 rejected, 2 repeat, 3 new code), m_tdata the
// last valid code (addr, ~addr, cmd, ~cmd from the low byte up).
// Config channel: cfg_index selects one of five 16-bit limits, written when
// cfg_valid is high; cfg_ready is always high. Write only while idle.
// Timing: an event is registered on accept and decoded in the next cycle;
// a poll result then enters the result register that drives m_tvalid. One
// event per cycle is sustained while results are not stalled, set by the
// combinational width subtract, compare and code-bit update on the frame state.
// Reset: limits return to their defaults, the frame closes, the held code
// clears. A stalled result stays on m_* while edges keep flowing in; a poll
// waits in the input register, and s_tready drops once it is blocked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nec_ir_frame_decoder_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [necir_pkg::TIME_W-1:0]     s_tdata,   // [31:0] time_us
    input  logic [0:0]                       s_tuser,   // [0] command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [necir_pkg::CODE_W-1:0]     m_tdata,   // [31:0] code
    output logic [necir_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [necir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [necir_pkg::CFG_W-1:0]      cfg_data
);

    necir_pkg::cfg_t    cfg;
    necir_pkg::result_t res;
    logic               res_valid;
    logic               res_ready;

    necir_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    necir_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser[0]),
        .in_time_us (s_tdata),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    necir_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/necir_checker.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder checker
// Port-level assertions on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nec_ir_frame_decoder_core_defines.svh"

module necir_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [necir_pkg::CODE_W-1:0]     m_tdata,
    input logic [necir_pkg::STATUS_W-1:0]   m_tuser
);

    logic [necir_pkg::CODE_W-1:0] last_code_reg;

    // code of the last delivered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_code_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            last_code_reg <= m_tdata;
        end
    end

    `NECIR_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `NECIR_ASSERT_IMP(a_new_code_checked, aclk, aresetn, m_tvalid && (m_tuser == necir_pkg::STATUS_NEW), necir_pkg::complement_ok(m_tdata), "new code fails complement check")
    `NECIR_ASSERT_IMP(a_code_held, aclk, aresetn, m_tvalid && (m_tuser != necir_pkg::STATUS_NEW), m_tdata == last_code_reg, "held code changed without a new code")

endmodule

bind nec_ir_frame_decoder_core necir_checker u_necir_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder core testbench
// Drives timestamped edge and poll events into the decoder, predicts each
// poll answer with an in-bench decoder, and checks every result transfer
// field by field. Directed frames come first, then random frames over
// several limit settings, with random idling and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_EVENTS   = 300;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [necir_pkg::TIME_W-1:0]        s_tdata   = '0;
    logic [0:0]                          s_tuser   = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [necir_pkg::CODE_W-1:0]        m_tdata;
    logic [necir_pkg::STATUS_W-1:0]      m_tuser;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [necir_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [necir_pkg::CFG_W-1:0]         cfg_data  = '0;

    nec_ir_frame_decoder_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // decoder prediction state
    necir_pkg::cfg_t              limits;
    logic                         frame_open;
    int                           edges_seen;
    logic [necir_pkg::TIME_W-1:0] prev_edge_us;
    logic                         leader_good;
    logic                         repeat_mark;
    logic [necir_pkg::TIME_W-1:0] mark_width;
    logic [necir_pkg::CODE_W-1:0] code_acc;
    logic [necir_pkg::CODE_W-1:0] last_code;

    necir_pkg::result_t           poll_answers [$];

    logic [necir_pkg::TIME_W-1:0] clock_us;
    int src_idle_pct  = 20;
    int sink_idle_pct = 20;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_count    = 0;
    int quiet_cycles  = 0;
    int events_sent   = 0;
    int polls_sent    = 0;
    int answers_checked = 0;
    int bad_answers   = 0;
    int settings_used = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    function automatic necir_pkg::cfg_t make_limits(
        input logic [necir_pkg::CFG_W-1:0] silence,
        input logic [necir_pkg::CFG_W-1:0] lead_min,
        input logic [necir_pkg::CFG_W-1:0] lead_max,
        input logic [necir_pkg::CFG_W-1:0] gap,
        input logic [necir_pkg::CFG_W-1:0] one_min);
        necir_pkg::cfg_t c;
        c.silence_limit_us = silence;
        c.leader_min_us    = lead_min;
        c.leader_max_us    = lead_max;
        c.repeat_gap_us    = gap;
        c.one_bit_min_us   = one_min;
        return c;
    endfunction

    function automatic void reset_decoder_model();
        limits = make_limits(necir_pkg::RST_SILENCE_LIMIT, necir_pkg::RST_LEADER_MIN,
                             necir_pkg::RST_LEADER_MAX, necir_pkg::RST_REPEAT_GAP,
                             necir_pkg::RST_ONE_BIT_MIN);
        frame_open   = 1'b0;
        edges_seen   = 0;
        prev_edge_us = '0;
        leader_good  = 1'b0;
        repeat_mark  = 1'b0;
        mark_width   = '0;
        code_acc     = '0;
        last_code    = '0;
    endfunction

    function automatic logic [necir_pkg::STATUS_W-1:0] frame_verdict();
        logic [necir_pkg::STATUS_W-1:0] v;
        if (edges_seen < 4 || !leader_good)
            v = necir_pkg::STATUS_REJECT;
        else if (repeat_mark)
            v = necir_pkg::STATUS_REPEAT;
        else if (edges_seen < necir_pkg::FULL_FRAME_EDGES)
            v = necir_pkg::STATUS_REJECT;
        else if ((code_acc[7:0] ^ code_acc[15:8]) != necir_pkg::BYTE_MASK ||
                 (code_acc[23:16] ^ code_acc[31:24]) != necir_pkg::BYTE_MASK)
            v = necir_pkg::STATUS_REJECT;
        else begin
            last_code = code_acc;
            v = necir_pkg::STATUS_NEW;
        end
        frame_open = 1'b0;
        edges_seen = 0;
        return v;
    endfunction

    function automatic void decode_event(input logic cmd,
                                         input logic [necir_pkg::TIME_W-1:0] t);
        logic [necir_pkg::TIME_W-1:0] w;
        logic [necir_pkg::SUM_W-1:0]  pair_sum;
        int                           j;
        necir_pkg::result_t           r;
        w = t - prev_edge_us;
        if (cmd == necir_pkg::CMD_EDGE) begin
            if (!frame_open) begin
                frame_open  = 1'b1;
                edges_seen  = 0;
                leader_good = 1'b0;
                repeat_mark = 1'b0;
                mark_width  = '0;
                code_acc    = '0;
            end
            if (edges_seen < necir_pkg::EDGE_CAPACITY) begin
                if (edges_seen > 0) begin
                    j = edges_seen - 1;
                    if (j == 0)
                        leader_good = (w >= 32'(limits.leader_min_us)) &&
                                      (w <= 32'(limits.leader_max_us));
                    else if (j == 1)
                        repeat_mark = (w < 32'(limits.repeat_gap_us));
                    else if (((j - 2) % 2) == 0)
                        mark_width = w;
                    else begin
                        pair_sum = {1'b0, mark_width} + {1'b0, w};
                        if ((j - 2) / 2 < necir_pkg::CODE_W &&
                            pair_sum > 33'(limits.one_bit_min_us))
                            code_acc[(j - 2) / 2] = 1'b1;
                    end
                end
                prev_edge_us = t;
                edges_seen++;
            end
        end else begin
            r.status = necir_pkg::STATUS_IDLE;
            if (frame_open && edges_seen != 0 && w >= 32'(limits.silence_limit_us))
                r.status = frame_verdict();
            r.code = last_code;
            poll_answers.push_back(r);
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        necir_pkg::result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            answers_checked++;
            status_seen[m_tuser]++;
            if (poll_answers.size() == 0) begin
                if (bad_answers < 10)
                    $display("tb: unexpected result status %0d code %h", m_tuser, m_tdata);
                bad_answers++;
            end else begin
                e = poll_answers.pop_front();
                if (m_tuser !== e.status || m_tdata !== e.code) begin
                    if (bad_answers < 10)
                        $display("tb: mismatch status exp %0d got %0d, code exp %h got %h",
                                 e.status, m_tuser, e.code, m_tdata);
                    bad_answers++;
                end
            end
        end
    end

    // receiver: random idling, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_count  = HOLD_CYCLES;
        end
        if (hold_count > 0) begin
            hold_count--;
            m_tready <= 1'b0;
        end else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired, no transfer for %0d cycles", quiet_cycles);
            $display("tb: done, errors");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_event(input logic cmd, input logic [necir_pkg::TIME_W-1:0] t);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= t;
        do @(posedge aclk); while (!s_tready);
        decode_event(cmd, t);
        events_sent++;
        if (cmd == necir_pkg::CMD_POLL)
            polls_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (poll_answers.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [necir_pkg::CFG_IDX_W-1:0] idx,
                             input logic [necir_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_limits(input necir_pkg::cfg_t c);
        settle();
        write_reg(necir_pkg::REG_SILENCE_LIMIT, c.silence_limit_us);
        write_reg(necir_pkg::REG_LEADER_MIN,    c.leader_min_us);
        write_reg(necir_pkg::REG_LEADER_MAX,    c.leader_max_us);
        write_reg(necir_pkg::REG_REPEAT_GAP,    c.repeat_gap_us);
        write_reg(necir_pkg::REG_ONE_BIT_MIN,   c.one_bit_min_us);
        cfg_valid <= 1'b0;
        limits = c;
        settings_used++;
    endtask

    // edges of one frame; widths follow the current limits
    task automatic send_frame(input logic [necir_pkg::CODE_W-1:0] code, input int n_edges,
                              input bit rep, input bit bad_lead, input bit wide_pair);
        logic [necir_pkg::TIME_W-1:0] w;
        logic [necir_pkg::TIME_W-1:0] mark;
        logic [necir_pkg::TIME_W-1:0] room;
        int k, j;
        mark = '0;
        for (k = 0; k < n_edges; k++) begin
            w = '0;
            if (k == 1) begin
                if (bad_lead)
                    w = $urandom();
                else if (limits.leader_min_us > limits.leader_max_us)
                    w = $urandom_range(65535);
                else if ($urandom_range(7) == 0)
                    w = $urandom_range(1) ? 32'(limits.leader_min_us) :
                                            32'(limits.leader_max_us);
                else
                    w = $urandom_range(limits.leader_max_us, limits.leader_min_us);
            end else if (k == 2) begin
                if (rep)
                    w = (limits.repeat_gap_us == 0) ? 32'd0 :
                        $urandom_range(32'(limits.repeat_gap_us) - 32'd1);
                else
                    w = 32'(limits.repeat_gap_us) + (($urandom_range(3) == 0) ? 32'd0 :
                                                     $urandom_range(3000));
            end else if (k > 2) begin
                j = k - 3;
                if (j / 2 >= necir_pkg::CODE_W)
                    w = $urandom_range(3000);
                else if (j % 2 == 0) begin
                    mark = (wide_pair && j == 0) ? 32'hFFFF_FFFF :
                           $urandom_range(32'(limits.one_bit_min_us) / 2);
                    w = mark;
                end else if (wide_pair && j == 1)
                    w = 32'd1;
                else begin
                    room = 32'(limits.one_bit_min_us) - mark;
                    if (code[j / 2])
                        w = room + 32'd1 + (($urandom_range(7) == 0) ? 32'd0 :
                                            $urandom_range(1200));
                    else
                        w = room - (($urandom_range(7) == 0) ? 32'd0 : $urandom_range(room));
                end
            end
            clock_us = clock_us + w;
            send_event(necir_pkg::CMD_EDGE, clock_us);
        end
    endtask

    task automatic close_frame_poll(input bit early);
        logic [necir_pkg::TIME_W-1:0] last;
        last = clock_us;
        if (early && limits.silence_limit_us != 0)
            send_event(necir_pkg::CMD_POLL,
                       last + $urandom_range(32'(limits.silence_limit_us) - 32'd1));
        clock_us = last + 32'(limits.silence_limit_us) +
                   (($urandom_range(3) == 0) ? 32'd0 : $urandom_range(2000));
        send_event(necir_pkg::CMD_POLL, clock_us);
    endtask

    task automatic run_random_frame();
        int pick, n, k;
        logic [7:0] addr, cmd_byte;
        logic [necir_pkg::CODE_W-1:0] code;
        bit rep, bad_lead;
        pick     = $urandom_range(99);
        addr     = 8'($urandom_range(255));
        cmd_byte = 8'($urandom_range(255));
        code     = ($urandom_range(99) < 85) ? {~cmd_byte, cmd_byte, ~addr, addr} : $urandom();
        rep      = ($urandom_range(19) == 0);
        bad_lead = 1'b0;
        n        = 68;
        if (pick < 55)
            n = (pick < 10) ? $urandom_range(75, 67) : 68;
        else if (pick < 70) begin
            rep = 1'b1;
            n   = $urandom_range(6, 4);
        end else if (pick < 80)
            n = $urandom_range(66, 1);
        else if (pick < 90) begin
            bad_lead = 1'b1;
            n        = $urandom_range(68, 4);
        end
        if (pick < 90)
            send_frame(code, n, rep, bad_lead, $urandom_range(15) == 0);
        else begin
            for (k = $urandom_range(8, 1); k > 0; k--) begin
                if ($urandom_range(3) == 0)
                    send_event(1'($urandom_range(1)), $urandom());
                else begin
                    clock_us = clock_us + $urandom_range(20000);
                    send_event(1'($urandom_range(1)), clock_us);
                end
            end
        end
        close_frame_poll($urandom_range(9) < 3);
        if ($urandom_range(9) == 0)
            send_event(necir_pkg::CMD_POLL, $urandom());
    endtask

    task automatic test_idle_polls();
        send_event(necir_pkg::CMD_POLL, 32'h0000_0000);
        send_event(necir_pkg::CMD_POLL, 32'hFFFF_FFFF);
    endtask

    task automatic test_short_frames();
        clock_us = 32'hFFFF_F000;
        send_frame(32'h0, 1, 1'b0, 1'b0, 1'b0);
        close_frame_poll(1'b1);
        send_frame(32'h0, 3, 1'b0, 1'b0, 1'b0);
        close_frame_poll(1'b0);
        send_frame(32'hF708_FB04, 40, 1'b0, 1'b0, 1'b0);
        close_frame_poll(1'b0);
    endtask

    task automatic test_repeat_frames();
        send_frame(32'h0, 4, 1'b1, 1'b0, 1'b0);
        close_frame_poll(1'b0);
        send_frame(32'h0, 4, 1'b1, 1'b1, 1'b0);
        close_frame_poll(1'b0);
    endtask

    task automatic test_code_checks();
        send_frame(32'hF708_FB04, 68, 1'b0, 1'b0, 1'b0);
        close_frame_poll(1'b0);
        send_frame(32'hF708_FB05, 68, 1'b0, 1'b0, 1'b0);
        close_frame_poll(1'b0);
        send_frame(32'hA55A_7E81, 68, 1'b0, 1'b0, 1'b1);
        close_frame_poll(1'b0);
        send_frame(32'hBF40_FE01, 75, 1'b0, 1'b0, 1'b0);
        close_frame_poll(1'b1);
    endtask

    task automatic test_limit_extremes();
        program_limits(make_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_frame(32'hEF10_BC43, 68, 1'b0, 1'b0, 1'b0);
        close_frame_poll(1'b0);
        send_frame(32'h0, 4, 1'b0, 1'b0, 1'b0);
        close_frame_poll(1'b0);
        program_limits(make_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_frame(32'hEF10_BC43, 68, 1'b0, 1'b0, 1'b0);
        close_frame_poll(1'b1);
        send_frame(32'h0, 4, 1'b1, 1'b0, 1'b0);
        close_frame_poll(1'b0);
    endtask

    task automatic run_phase(input necir_pkg::cfg_t c, input int idle_pct);
        int ev0, po0;
        program_limits(c);
        src_idle_pct  = idle_pct;
        sink_idle_pct = idle_pct;
        ev0 = events_sent;
        po0 = polls_sent;
        while (events_sent - ev0 < PHASE_EVENTS || polls_sent - po0 < 8)
            run_random_frame();
    endtask

    task automatic test_random_traffic();
        logic [necir_pkg::CFG_W-1:0] lo;
        run_phase(make_limits(necir_pkg::RST_SILENCE_LIMIT, necir_pkg::RST_LEADER_MIN,
                              necir_pkg::RST_LEADER_MAX, necir_pkg::RST_REPEAT_GAP,
                              necir_pkg::RST_ONE_BIT_MIN), 20);
        lo = 16'($urandom_range(30000));
        run_phase(make_limits(16'($urandom_range(65535)), lo,
                              16'(lo + $urandom_range(30000)),
                              16'($urandom_range(65535)), 16'($urandom_range(65535))), 0);
        lo = 16'($urandom_range(65535, 1));
        run_phase(make_limits(16'($urandom_range(2000)), lo, lo - 16'd1,
                              16'($urandom_range(5000)), 16'($urandom_range(3000))), 20);
        run_phase(make_limits(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000), 20);
    endtask

    task automatic test_backpressure();
        int k;
        settle();
        src_idle_pct = 0;
        hold_requests++;
        for (k = 0; k < 4; k++) begin
            send_event(necir_pkg::CMD_POLL, clock_us);
            run_random_frame();
        end
        src_idle_pct = 20;
    endtask

    initial begin
        reset_decoder_model();
        clock_us = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_polls();
        test_short_frames();
        test_repeat_frames();
        test_code_checks();
        test_limit_extremes();
        test_random_traffic();
        test_backpressure();
        settle();

        bad_answers += poll_answers.size();
        $display("tb: %0d events sent (%0d polls), %0d results checked over %0d limit settings",
                 events_sent, polls_sent, answers_checked, settings_used);
        $display("tb: results idle %0d, rejected %0d, repeat %0d, new code %0d",
                 status_seen[necir_pkg::STATUS_IDLE], status_seen[necir_pkg::STATUS_REJECT],
                 status_seen[necir_pkg::STATUS_REPEAT], status_seen[necir_pkg::STATUS_NEW]);
        if (bad_answers == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== nec_ir_frame_decoder_core.f =====
+incdir+rtl
rtl/necir_pkg.sv
rtl/necir_cfg.sv
rtl/necir_decode.sv
rtl/necir_outbuf.sv
rtl/nec_ir_frame_decoder_core.sv
rtl/necir_checker.sv
tb/tb.sv
